### sv/three_axis_zero_offset_averager_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis zero-offset averager
// Shorthand for the clocked, reset-gated properties at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_ZERO_OFFSET_AVERAGER_ASSERT_SVH
`define THREE_AXIS_ZERO_OFFSET_AVERAGER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TZOA_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TZOA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tzoa_pkg.sv
// ----------------------------------------------------------------------------
// tzoa_pkg
// Widths, codes and shared types of the three-axis zero-offset averager.
// ----------------------------------------------------------------------------
package tzoa_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned N_AXES     = 3;

  localparam int unsigned DISCARD_COUNT_DEF = 5;

  // one restoring step per dividend bit
  localparam int unsigned DIV_STEPS = SUM_W;
  // step counter runs 0 (load) .. DIV_STEPS+1 (done)
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 2);

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_READING = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN   = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = CNT_W'(16);
  localparam logic             BIG_ENDIAN_RST   = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISCARD,
    ST_SUM,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic clear_sums;
    logic accumulate;
    logic div_start;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

endpackage

### sv/tzoa_in_if.sv
// ----------------------------------------------------------------------------
// tzoa_in_if
// Input channel: command and six raw sensor bytes per beat.
// ----------------------------------------------------------------------------
interface tzoa_in_if;
  import tzoa_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] raw_byte_0;
  logic [BYTE_W-1:0] raw_byte_1;
  logic [BYTE_W-1:0] raw_byte_2;
  logic [BYTE_W-1:0] raw_byte_3;
  logic [BYTE_W-1:0] raw_byte_4;
  logic [BYTE_W-1:0] raw_byte_5;

  modport source (
    output valid, command, raw_byte_0, raw_byte_1, raw_byte_2,
    output raw_byte_3, raw_byte_4, raw_byte_5,
    input  ready
  );

  modport sink (
    input  valid, command, raw_byte_0, raw_byte_1, raw_byte_2,
    input  raw_byte_3, raw_byte_4, raw_byte_5,
    output ready
  );
endinterface

### sv/tzoa_out_if.sv
// ----------------------------------------------------------------------------
// tzoa_out_if
// Result channel: the three averaged axis offsets.
// ----------------------------------------------------------------------------
interface tzoa_out_if;
  import tzoa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] offset_x;
  logic signed [WORD_W-1:0] offset_y;
  logic signed [WORD_W-1:0] offset_z;

  modport source (
    output valid, offset_x, offset_y, offset_z,
    input  ready
  );

  modport sink (
    input  valid, offset_x, offset_y, offset_z,
    output ready
  );
endinterface

### sv/tzoa_cfg_if.sv
// ----------------------------------------------------------------------------
// tzoa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tzoa_cfg_if;
  import tzoa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

### sv/tzoa_div.sv
// ----------------------------------------------------------------------------
// tzoa_div
// Sequential signed-by-unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module tzoa_div (
  input  logic                             clk_i,
  input  logic                             start_i,
  input  logic                             step_i,
  input  logic signed [tzoa_pkg::SUM_W-1:0] dividend_i,
  input  logic [tzoa_pkg::CNT_W-1:0]       divisor_i,
  output logic [tzoa_pkg::WORD_W-1:0]      quotient_o
);
  import tzoa_pkg::*;

  logic [SUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] dvs_q;
  logic             neg_q;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             fits;

  // shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    rem_d = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    quo_d = {quo_q[SUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      // magnitude of the most negative sum still fits as unsigned
      quo_q <= dividend_i[SUM_W-1] ? (~dividend_i + SUM_W'(1)) : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // truncation toward zero falls out of dividing the magnitude
  assign quotient_o = neg_q ? (~quo_q[WORD_W-1:0] + WORD_W'(1)) : quo_q[WORD_W-1:0];

endmodule

### sv/tzoa_dp.sv
// ----------------------------------------------------------------------------
// tzoa_dp
// Datapath: word assembly, per-axis sums, dividers and result register.
// ----------------------------------------------------------------------------
module tzoa_dp (
  input  logic                                clk_i,
  input  tzoa_pkg::dp_cmd_t                   cmd_i,
  input  logic                                big_endian_i,
  input  logic [tzoa_pkg::CNT_W-1:0]          sample_count_i,
  input  logic [tzoa_pkg::BYTE_W-1:0]         raw_byte_0_i,
  input  logic [tzoa_pkg::BYTE_W-1:0]         raw_byte_1_i,
  input  logic [tzoa_pkg::BYTE_W-1:0]         raw_byte_2_i,
  input  logic [tzoa_pkg::BYTE_W-1:0]         raw_byte_3_i,
  input  logic [tzoa_pkg::BYTE_W-1:0]         raw_byte_4_i,
  input  logic [tzoa_pkg::BYTE_W-1:0]         raw_byte_5_i,
  output logic signed [tzoa_pkg::WORD_W-1:0]  offset_x_o,
  output logic signed [tzoa_pkg::WORD_W-1:0]  offset_y_o,
  output logic signed [tzoa_pkg::WORD_W-1:0]  offset_z_o
);
  import tzoa_pkg::*;

  logic [BYTE_W-1:0]        raw   [2*N_AXES];
  logic [WORD_W-1:0]        word  [N_AXES];
  logic signed [SUM_W-1:0]  sum_q [N_AXES];
  logic [WORD_W-1:0]        quot  [N_AXES];
  logic [WORD_W-1:0]        res_q [N_AXES];
  logic [CNT_W-1:0]         divisor;

  assign raw[0] = raw_byte_0_i;
  assign raw[1] = raw_byte_1_i;
  assign raw[2] = raw_byte_2_i;
  assign raw[3] = raw_byte_3_i;
  assign raw[4] = raw_byte_4_i;
  assign raw[5] = raw_byte_5_i;

  // a zero count is read as one
  assign divisor = (sample_count_i == '0) ? CNT_W'(1) : sample_count_i;

  for (genvar a = 0; a < N_AXES; a++) begin : g_axis
    assign word[a] = big_endian_i ? {raw[2*a], raw[2*a+1]} : {raw[2*a+1], raw[2*a]};

    always_ff @(posedge clk_i) begin
      if (cmd_i.clear_sums) begin
        sum_q[a] <= '0;
      end else if (cmd_i.accumulate) begin
        sum_q[a] <= sum_q[a] + {{(SUM_W-WORD_W){word[a][WORD_W-1]}}, word[a]};
      end
    end

    tzoa_div u_div (
      .clk_i      (clk_i),
      .start_i    (cmd_i.div_start),
      .step_i     (cmd_i.div_step),
      .dividend_i (sum_q[a]),
      .divisor_i  (divisor),
      .quotient_o (quot[a])
    );

    always_ff @(posedge clk_i) begin
      if (cmd_i.load_out) begin
        res_q[a] <= quot[a];
      end
    end
  end

  assign offset_x_o = res_q[0];
  assign offset_y_o = res_q[1];
  assign offset_z_o = res_q[2];

endmodule

### sv/tzoa_ctrl.sv
// ----------------------------------------------------------------------------
// tzoa_ctrl
// Controller: run phases, reading counter, divide sequencing, result valid.
// ----------------------------------------------------------------------------
module tzoa_ctrl #(
  parameter int unsigned DISCARD_COUNT = tzoa_pkg::DISCARD_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_command_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  logic [tzoa_pkg::CNT_W-1:0] sample_count_i,
  output tzoa_pkg::dp_cmd_t          cmd_o,
  output logic                       busy_o
);
  import tzoa_pkg::*;

  localparam logic [CNT_W-1:0]  DiscardLim = CNT_W'(DISCARD_COUNT);
  localparam logic [STEP_W-1:0] StepDone   = STEP_W'(DIV_STEPS + 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  logic              accept;
  logic              is_start;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  n_eff;
  logic              discard_end;
  logic              sum_end;
  logic              out_free;

  assign in_ready_o  = (state_q != ST_DIV);
  assign accept      = in_valid_i && in_ready_o;
  assign is_start    = (in_command_i == CMD_START);
  assign idx_inc     = idx_q + CNT_W'(1);
  assign n_eff       = (sample_count_i == '0) ? CNT_W'(1) : sample_count_i;
  assign discard_end = (idx_inc >= DiscardLim);
  assign sum_end     = (idx_inc >= n_eff);
  assign out_free    = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_DISCARD, ST_SUM: begin
        if (accept) begin
          if (is_start) begin
            state_d = (DISCARD_COUNT == 0) ? ST_SUM : ST_DISCARD;
          end else if (state_q == ST_DISCARD && discard_end) begin
            state_d = ST_SUM;
          end else if (state_q == ST_SUM && sum_end) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (step_q == StepDone && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and counters
  always_comb begin
    cmd_o       = '0;
    idx_d       = idx_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE, ST_DISCARD, ST_SUM: begin
        step_d = '0;
        if (accept) begin
          if (is_start) begin
            cmd_o.clear_sums = 1'b1;
            idx_d            = '0;
          end else if (state_q == ST_DISCARD) begin
            idx_d = discard_end ? '0 : idx_inc;
          end else if (state_q == ST_SUM) begin
            cmd_o.accumulate = 1'b1;
            idx_d            = sum_end ? '0 : idx_inc;
          end
        end
      end
      ST_DIV: begin
        if (step_q == '0) begin
          cmd_o.div_start = 1'b1;
          step_d          = step_q + STEP_W'(1);
        end else if (step_q != StepDone) begin
          cmd_o.div_step = 1'b1;
          step_d         = step_q + STEP_W'(1);
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign busy_o      = (state_q == ST_DIV);

endmodule

### sv/three_axis_zero_offset_averager.sv
// ----------------------------------------------------------------------------
// three_axis_zero_offset_averager
// Zero-offset calibration: discards settling readings, averages the rest.
//
//   channel  dir  beat contents
//   in_i     in   command, raw_byte_0..raw_byte_5
//   out_o    out  offset_x, offset_y, offset_z
//   cfg_i    in   index, data (0 sample_count, 1 big_endian)
//
// A reading or start beat is taken every cycle while no divide is running.
// The last summed reading starts the divide: 1 load + 24 shift-subtract
// steps, then the result goes to the output register, with in_i not
// ready. If the previous result is still stalled, the load holds until
// it leaves. Asynchronous active-low reset returns to idle; cfg is always
// ready and takes effect in the next cycle.
// ----------------------------------------------------------------------------
module three_axis_zero_offset_averager #(
  parameter int unsigned DISCARD_COUNT = tzoa_pkg::DISCARD_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tzoa_in_if.sink     in_i,
  tzoa_out_if.source  out_o,
  tzoa_cfg_if.sink    cfg_i
);
  import tzoa_pkg::*;

  `include "three_axis_zero_offset_averager_assert.svh"

  logic [CNT_W-1:0] sample_count_q;
  logic             big_endian_q;
  dp_cmd_t          dp_cmd;
  logic             ctrl_busy;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= SAMPLE_COUNT_RST;
      big_endian_q   <= BIG_ENDIAN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SAMPLE_COUNT: sample_count_q <= cfg_i.data[CNT_W-1:0];
        REG_BIG_ENDIAN:   big_endian_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  tzoa_ctrl #(
    .DISCARD_COUNT (DISCARD_COUNT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_command_i   (in_i.command),
    .in_ready_o     (in_i.ready),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .sample_count_i (sample_count_q),
    .cmd_o          (dp_cmd),
    .busy_o         (ctrl_busy)
  );

  tzoa_dp u_dp (
    .clk_i          (clk_i),
    .cmd_i          (dp_cmd),
    .big_endian_i   (big_endian_q),
    .sample_count_i (sample_count_q),
    .raw_byte_0_i   (in_i.raw_byte_0),
    .raw_byte_1_i   (in_i.raw_byte_1),
    .raw_byte_2_i   (in_i.raw_byte_2),
    .raw_byte_3_i   (in_i.raw_byte_3),
    .raw_byte_4_i   (in_i.raw_byte_4),
    .raw_byte_5_i   (in_i.raw_byte_5),
    .offset_x_o     (out_o.offset_x),
    .offset_y_o     (out_o.offset_y),
    .offset_z_o     (out_o.offset_z)
  );

  // no input beat may land while the dividers are working on the sums
  `TZOA_ASSERT_NOW(a_busy_blocks_input, clk_i, rst_ni, ctrl_busy, !in_i.ready, "beat taken during divide")

  // a fresh result only appears after the input has been held off
  `TZOA_ASSERT_NOW(a_result_after_divide, clk_i, rst_ni, $rose(out_o.valid), $past(!in_i.ready), "result without divide")

  // a start beat never produces a result straight away
  `TZOA_ASSERT_NEXT(a_start_no_result, clk_i, rst_ni, in_i.valid && in_i.ready && (in_i.command == CMD_START), !$rose(out_o.valid), "result after start")

endmodule
